[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mcer_pkg.sv]
package mcer_pkg;

  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RASTER_OP        = 3'd0,
    REG_FG_COLOR         = 3'd1,
    REG_BG_COLOR         = 3'd2,
    REG_TRANSPARENT_MASK = 3'd3,
    REG_RECT_WIDTH       = 3'd4,
    REG_RECT_HEIGHT      = 3'd5,
    REG_FIRST_BIT_OFFSET = 3'd6,
    REG_SRC_STRIDE       = 3'd7
  } reg_idx_t;

  localparam logic [2:0] ROP_COPY = 3'd0;
  localparam logic [2:0] ROP_AND  = 3'd1;
  localparam logic [2:0] ROP_OR   = 3'd2;
  localparam logic [2:0] ROP_XOR  = 3'd3;

  localparam logic [2:0]  RASTER_OP_RST = ROP_COPY;
  localparam logic [7:0]  FG_COLOR_RST  = 8'hFF;
  localparam logic [7:0]  BG_COLOR_RST  = 8'h00;
  localparam logic [1:0]  TMASK_RST     = 2'd0;
  localparam logic [12:0] RECT_DIM_RST  = 13'd1;
  localparam logic [2:0]  FBO_RST       = 3'd0;
  localparam logic [15:0] STRIDE_RST    = 16'd8;

  typedef struct packed {
    logic [7:0]  src_byte;
    logic [63:0] old_pixels;
    logic [2:0]  start_bit;
    logic [2:0]  last_k;
    logic        row_done;
    logic        rect_done;
  } item_t;

  typedef struct packed {
    logic [2:0] raster_op;
    logic [7:0] fg_color;
    logic [7:0] bg_color;
    logic [1:0] transparent_mask;
  } pix_cfg_t;

endpackage

[rtl/mcer_front.sv]
module mcer_front
  import mcer_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic [7:0]            in_src_byte,
  input  logic [63:0]           in_old_pixels,
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item,
  output pix_cfg_t              pix_cfg
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CW    = (DIM_W > 13) ? DIM_W : 13;

  logic [2:0]  raster_op_r;
  logic [7:0]  fg_color_r;
  logic [7:0]  bg_color_r;
  logic [1:0]  tmask_r;
  logic [12:0] rect_width_r;
  logic [12:0] rect_height_r;
  logic [2:0]  fbo_r;
  logic [15:0] stride_r;

  logic [CW-1:0] column_r, column_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [2:0]    bitpos_r, bitpos_nxt;
  logic [2:0]    rowstart_r, rowstart_nxt;

  logic [CW-1:0] width_ext, height_ext, width_c, height_c, left, avail_ext;
  logic [3:0]    avail, count;
  logic          row_done, rect_done, accept, geom_wr;
  logic [2:0]    fbo_new;

  always_comb begin
    width_ext  = CW'(rect_width_r);
    height_ext = CW'(rect_height_r);
    if (width_ext == '0) begin
      width_c = CW'(1);
    end else if (width_ext > CW'(MAX_DIM)) begin
      width_c = CW'(MAX_DIM);
    end else begin
      width_c = width_ext;
    end
    if (height_ext == '0) begin
      height_c = CW'(1);
    end else if (height_ext > CW'(MAX_DIM)) begin
      height_c = CW'(MAX_DIM);
    end else begin
      height_c = height_ext;
    end
    left      = width_c - column_r;
    avail     = 4'd8 - {1'b0, bitpos_r};
    avail_ext = CW'(avail);
    row_done  = (left <= avail_ext);
    count     = (left < avail_ext) ? left[3:0] : avail;
    rect_done = row_done && (({1'b0, row_r} + (CW+1)'(1)) >= {1'b0, height_c});
  end

  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    q_item.src_byte   = in_src_byte;
    q_item.old_pixels = in_old_pixels;
    q_item.start_bit  = bitpos_r;
    q_item.last_k     = 3'(count - 4'd1);
    q_item.row_done   = row_done;
    q_item.rect_done  = rect_done;
  end

  assign pix_cfg.raster_op        = raster_op_r;
  assign pix_cfg.fg_color         = fg_color_r;
  assign pix_cfg.bg_color         = bg_color_r;
  assign pix_cfg.transparent_mask = tmask_r;

  assign geom_wr = cfg_we && ((cfg_idx == REG_RECT_WIDTH) || (cfg_idx == REG_RECT_HEIGHT) ||
                              (cfg_idx == REG_FIRST_BIT_OFFSET) ||
                              (cfg_idx == REG_SRC_STRIDE));
  assign fbo_new = (cfg_idx == REG_FIRST_BIT_OFFSET) ? cfg_data[2:0] : fbo_r;

  always_comb begin
    column_nxt   = column_r;
    row_nxt      = row_r;
    bitpos_nxt   = bitpos_r;
    rowstart_nxt = rowstart_r;
    if (geom_wr) begin
      column_nxt   = '0;
      row_nxt      = '0;
      rowstart_nxt = fbo_new;
      bitpos_nxt   = fbo_new;
    end else if (accept) begin
      if (row_done) begin
        column_nxt = '0;
        if (rect_done) begin
          row_nxt      = '0;
          rowstart_nxt = fbo_r;
          bitpos_nxt   = fbo_r;
        end else begin
          row_nxt      = row_r + CW'(1);
          rowstart_nxt = rowstart_r + stride_r[2:0];
          bitpos_nxt   = rowstart_r + stride_r[2:0];
        end
      end else begin
        column_nxt = column_r + CW'(count);
        bitpos_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_op_r   <= RASTER_OP_RST;
      fg_color_r    <= FG_COLOR_RST;
      bg_color_r    <= BG_COLOR_RST;
      tmask_r       <= TMASK_RST;
      rect_width_r  <= RECT_DIM_RST;
      rect_height_r <= RECT_DIM_RST;
      fbo_r         <= FBO_RST;
      stride_r      <= STRIDE_RST;
      column_r      <= '0;
      row_r         <= '0;
      bitpos_r      <= FBO_RST;
      rowstart_r    <= FBO_RST;
    end else begin
      column_r   <= column_nxt;
      row_r      <= row_nxt;
      bitpos_r   <= bitpos_nxt;
      rowstart_r <= rowstart_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_RASTER_OP:        raster_op_r   <= cfg_data[2:0];
          REG_FG_COLOR:         fg_color_r    <= cfg_data[7:0];
          REG_BG_COLOR:         bg_color_r    <= cfg_data[7:0];
          REG_TRANSPARENT_MASK: tmask_r       <= cfg_data[1:0];
          REG_RECT_WIDTH:       rect_width_r  <= cfg_data[12:0];
          REG_RECT_HEIGHT:      rect_height_r <= cfg_data[12:0];
          REG_FIRST_BIT_OFFSET: fbo_r         <= cfg_data[2:0];
          REG_SRC_STRIDE:       stride_r      <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/mcer_queue.sv]
module mcer_queue
  import mcer_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  valid
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  item_t         slots_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == NW'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_item = slots_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + NW'(do_wr) - NW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[rtl/mcer_back.sv]
module mcer_back
  import mcer_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  item_t    q_item,
  input  pix_cfg_t pix_cfg,
  output logic     q_pop,
  input  logic     pop,
  output logic     empty,
  output logic [7:0] out_new_pixel,
  output logic     out_write_enable,
  output logic     out_row_end,
  output logic     out_rect_end,
  output logic     out_last_of_byte
);

  logic [2:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] pixel_r;
  logic       we_r, row_end_r, rect_end_r, last_r;

  logic [2:0] bit_idx;
  logic       set, transparent, we, last, load;
  logic [7:0] old, colour, result;

  always_comb begin
    bit_idx     = q_item.start_bit + k_r;
    set         = q_item.src_byte[3'd7 - bit_idx];
    old         = q_item.old_pixels[{k_r, 3'b000} +: 8];
    colour      = set ? pix_cfg.fg_color : pix_cfg.bg_color;
    transparent = set ? pix_cfg.transparent_mask[0] : pix_cfg.transparent_mask[1];
    last        = (k_r == q_item.last_k);
    result      = old;
    we          = 1'b0;
    if (!transparent) begin
      we = 1'b1;
      case (pix_cfg.raster_op)
        ROP_COPY: result = colour;
        ROP_AND:  result = old & colour;
        ROP_OR:   result = old | colour;
        ROP_XOR:  result = old ^ colour;
        default:  we = 1'b0;
      endcase
    end
  end

  assign load          = q_valid && (!out_valid_r || pop);
  assign q_pop         = load && last;
  assign k_nxt         = load ? (last ? 3'd0 : k_r + 3'd1) : k_r;
  assign out_valid_nxt = load || (out_valid_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r    <= result;
      we_r       <= we;
      row_end_r  <= last && q_item.row_done;
      rect_end_r <= last && q_item.rect_done;
      last_r     <= last;
    end
  end

  assign empty            = !out_valid_r;
  assign out_new_pixel    = pixel_r;
  assign out_write_enable = we_r;
  assign out_row_end      = row_end_r;
  assign out_rect_end     = rect_end_r;
  assign out_last_of_byte = last_r;

endmodule

[rtl/mono_color_expand_rop_core.sv]
// Channel   Handshake              Payload
// input     push / full            in_src_byte, in_old_pixels
// result    empty / pop            out_new_pixel, out_write_enable, out_row_end,
//                                  out_rect_end, out_last_of_byte
// config    cfg_we                 cfg_idx, cfg_data
//
// A source byte gives 1 to 8 pixels, one per cycle from the pixel unit in the back end while
// the output register is popped; the byte's queue entry is freed when its last pixel is loaded.
// A two-entry request queue lets the front accept while the back end still works.
// An accepted request is written into the queue; its first result then goes to the output register.
// Synchronous active-low reset clears the queue, the output stage and the counters and restores the config registers.
// The output register holds while pop is low; the queue then fills and raises full.
module mono_color_expand_rop_core
  import mcer_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_src_byte,
  input  logic [63:0]           in_old_pixels,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_new_pixel,
  output logic                  out_write_enable,
  output logic                  out_row_end,
  output logic                  out_rect_end,
  output logic                  out_last_of_byte
);

  logic     q_push, q_pop, q_valid;
  item_t    wr_item, rd_item;
  pix_cfg_t pix_cfg;

  mcer_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .push          (push),
    .in_src_byte   (in_src_byte),
    .in_old_pixels (in_old_pixels),
    .q_full        (full),
    .q_push        (q_push),
    .q_item        (wr_item),
    .pix_cfg       (pix_cfg)
  );

  mcer_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (wr_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (rd_item),
    .valid   (q_valid)
  );

  mcer_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (rd_item),
    .pix_cfg          (pix_cfg),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_new_pixel    (out_new_pixel),
    .out_write_enable (out_write_enable),
    .out_row_end      (out_row_end),
    .out_rect_end     (out_rect_end),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule

[rtl/mcer_checker.sv]
`include "assert_macros.svh"

module mcer_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_new_pixel,
  input logic       out_row_end,
  input logic       out_rect_end,
  input logic       out_last_of_byte
);

  `ASSERT_CLKD(a_rect_end_on_row_end, clk, rst_n, (!empty && out_rect_end) |-> out_row_end, "rect_end without row_end")
  `ASSERT_CLKD(a_row_end_on_last, clk, rst_n, (!empty && out_row_end) |-> out_last_of_byte, "row_end before last pixel of byte")
  `ASSERT_CLK(a_reset_clears, clk, !rst_n |=> (empty && !full), "queue not cleared by reset")
  `ASSERT_CLKD(a_stall_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_new_pixel)), "stalled result changed")

endmodule

bind mono_color_expand_rop_core mcer_checker u_mcer_checker (.*);

[tb/mono_color_expand_rop_core_tb.sv]
`timescale 1ns / 1ps

module mono_color_expand_rop_core_tb;
  import mcer_pkg::*;

  localparam int RAND_ITEMS = 400;
  localparam int SETTLE     = 6;
  localparam int TAIL       = 20;
  localparam int LIMIT      = 400000;
  localparam int DIM_MAX    = 4096;

  localparam logic [2:0] ROP_NOP_FIRST = 3'd4;
  localparam logic [2:0] ROP_NOP_LAST  = 3'd7;
  localparam logic [1:0] TM_NONE = 2'd0;
  localparam logic [1:0] TM_FG   = 2'd1;
  localparam logic [1:0] TM_BG   = 2'd2;
  localparam logic [1:0] TM_BOTH = 2'd3;

  typedef struct packed {
    logic [7:0] pix;
    logic       wr;
    logic       row_end;
    logic       rect_end;
    logic       last;
  } pixel_res_t;

  typedef struct packed {
    logic       is_cfg;
    reg_idx_t   idx;
    logic [15:0] data;
    logic [7:0] src;
    logic [63:0] old;
    logic       typed;
    pixel_res_t want;
  } plan_row_t;

  localparam pixel_res_t NO_PIX = '0;
  localparam int PLAN_LEN = 47;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h80, 64'hFFEE_DDCC_BBAA_9900, 1'b1,
      '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h7F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_RASTER_OP, {13'h0, ROP_AND}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h80, 64'h0123_4567_89AB_CD5A, 1'b1,
      '{8'h5A, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_FG_COLOR, 16'h000F, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'hFF, 64'h5555_AAAA_5555_AAF0, 1'b1,
      '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_RASTER_OP, {13'h0, ROP_OR}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h00, 64'h8000_0000_0000_0012, 1'b1,
      '{8'h12, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_RASTER_OP, {13'h0, ROP_XOR}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h80, 64'h0000_0000_0000_00FF, 1'b1,
      '{8'hF0, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_RASTER_OP, {13'h0, ROP_NOP_FIRST}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h80, 64'h1111_2222_3333_44AB, 1'b1,
      '{8'hAB, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_RASTER_OP, {13'h0, ROP_NOP_LAST}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h00, 64'h0, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_RASTER_OP, {13'h0, ROP_COPY}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_TRANSPARENT_MASK, {14'h0, TM_FG}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h80, 64'hCAFE_0000_0000_0033, 1'b1,
      '{8'h33, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h00, 64'hCAFE_0000_0000_0033, 1'b1,
      '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_TRANSPARENT_MASK, {14'h0, TM_BG}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_BG_COLOR, 16'h00C3, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h00, 64'h0000_0000_0000_0044, 1'b1,
      '{8'h44, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h80, 64'h0000_0000_0000_0044, 1'b1,
      '{8'h0F, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_TRANSPARENT_MASK, {14'h0, TM_BOTH}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h55, 64'h7777_7777_7777_7766, 1'b1,
      '{8'h66, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_TRANSPARENT_MASK, {14'h0, TM_NONE}, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_RECT_WIDTH, 16'h0000, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_RECT_HEIGHT, 16'h0000, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h00, 64'h0, 1'b1,
      '{8'hC3, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, REG_RECT_WIDTH, 16'hFFFF, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_RECT_HEIGHT, 16'hFFFF, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h00, 64'h0123_4567_89AB_CDEF, 1'b0, NO_PIX},
    '{1'b1, REG_FIRST_BIT_OFFSET, 16'h0007, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_RECT_WIDTH, 16'h0003, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_RECT_HEIGHT, 16'h0002, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b1, REG_SRC_STRIDE, 16'h0000, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h01, 64'h0102_0304_0506_0708, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'hC0, 64'h1122_3344_5566_7788, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'hFF, 64'h99AA_BBCC_DDEE_FF00, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h80, 64'hF0E1_D2C3_B4A5_9687, 1'b0, NO_PIX},
    '{1'b1, REG_SRC_STRIDE, 16'hFFFF, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'hA5, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h5A, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h3C, 64'hAAAA_5555_AAAA_5555, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'hC3, 64'h5555_AAAA_5555_AAAA, 1'b0, NO_PIX},
    '{1'b1, REG_RASTER_OP, 16'hFFF8, 8'h00, 64'h0, 1'b0, NO_PIX},
    '{1'b0, REG_RASTER_OP, 16'h0, 8'h96, 64'h8421_8421_8421_8421, 1'b0, NO_PIX}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            in_src_byte = '0;
  logic [63:0]           in_old_pixels = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            out_new_pixel;
  logic                  out_write_enable;
  logic                  out_row_end;
  logic                  out_rect_end;
  logic                  out_last_of_byte;

  mono_color_expand_rop_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .in_src_byte      (in_src_byte),
    .in_old_pixels    (in_old_pixels),
    .empty            (empty),
    .pop              (pop),
    .out_new_pixel    (out_new_pixel),
    .out_write_enable (out_write_enable),
    .out_row_end      (out_row_end),
    .out_rect_end     (out_rect_end),
    .out_last_of_byte (out_last_of_byte)
  );

  always #5 clk = ~clk;

  // blitter shadow state
  logic [2:0]  sh_rop;
  logic [7:0]  sh_fg;
  logic [7:0]  sh_bg;
  logic [1:0]  sh_tmask;
  logic [12:0] sh_width;
  logic [12:0] sh_height;
  logic [2:0]  sh_first_bit;
  logic [15:0] sh_stride;
  int          col_cnt;
  int          row_cnt;
  logic [2:0]  bit_pos;
  logic [2:0]  row_off;

  pixel_res_t  pixel_q [$];
  pixel_res_t  byte_pix [8];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int pixels_checked = 0;
  int rects_closed = 0;
  int cfg_writes = 0;
  int push_idle_pct = 20;
  int pop_idle_pct = 20;
  int pop_gap = 0;
  bit quiet = 1'b0;
  bit need_drain = 1'b0;

  function automatic int dim_clamp(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  function automatic void restart_rect();
    col_cnt = 0;
    row_cnt = 0;
    row_off = sh_first_bit;
    bit_pos = sh_first_bit;
  endfunction

  function automatic void shadow_reset();
    sh_rop       = RASTER_OP_RST;
    sh_fg        = FG_COLOR_RST;
    sh_bg        = BG_COLOR_RST;
    sh_tmask     = TMASK_RST;
    sh_width     = RECT_DIM_RST;
    sh_height    = RECT_DIM_RST;
    sh_first_bit = FBO_RST;
    sh_stride    = STRIDE_RST;
    restart_rect();
  endfunction

  function automatic void shadow_write(input reg_idx_t r, input logic [15:0] v);
    case (r)
      REG_RASTER_OP:        sh_rop = v[2:0];
      REG_FG_COLOR:         sh_fg = v[7:0];
      REG_BG_COLOR:         sh_bg = v[7:0];
      REG_TRANSPARENT_MASK: sh_tmask = v[1:0];
      REG_RECT_WIDTH: begin
        sh_width = v[12:0];
        restart_rect();
      end
      REG_RECT_HEIGHT: begin
        sh_height = v[12:0];
        restart_rect();
      end
      REG_FIRST_BIT_OFFSET: begin
        sh_first_bit = v[2:0];
        restart_rect();
      end
      REG_SRC_STRIDE: begin
        sh_stride = v;
        restart_rect();
      end
      default: ;
    endcase
  endfunction

  // Fill byte_pix with the pixels one source byte expands to; return their count.
  function automatic int expand_byte(input logic [7:0] src, input logic [63:0] old);
    int         w;
    int         h;
    int         b;
    int         left;
    int         cnt;
    logic       row_done;
    logic       rect_done;
    logic       set_bit;
    logic       see_through;
    logic       last;
    logic [7:0] prev;
    logic [7:0] colour;
    logic [7:0] res;
    logic       wr;
    w = dim_clamp(sh_width);
    h = dim_clamp(sh_height);
    b = int'(bit_pos);
    left = w - col_cnt;
    cnt = (left < 8 - b) ? left : 8 - b;
    row_done = (left <= 8 - b);
    rect_done = row_done && (row_cnt + 1 >= h);
    for (int k = 0; k < cnt; k++) begin
      set_bit = src[7 - (b + k)];
      prev = old[8*k +: 8];
      colour = set_bit ? sh_fg : sh_bg;
      see_through = set_bit ? sh_tmask[0] : sh_tmask[1];
      last = (k + 1 == cnt);
      res = prev;
      wr = 1'b0;
      if (!see_through) begin
        wr = 1'b1;
        case (sh_rop)
          ROP_COPY: res = colour;
          ROP_AND:  res = prev & colour;
          ROP_OR:   res = prev | colour;
          ROP_XOR:  res = prev ^ colour;
          default:  wr = 1'b0;
        endcase
      end
      byte_pix[k] = '{res, wr, last && row_done, last && rect_done, last};
    end
    if (row_done) begin
      col_cnt = 0;
      if (rect_done) begin
        restart_rect();
      end else begin
        row_cnt++;
        row_off = row_off + sh_stride[2:0];
        bit_pos = row_off;
      end
    end else begin
      col_cnt += cnt;
      bit_pos = 3'd0;
    end
    return cnt;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels still expected", cycles, pixel_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check accepted pixels, then pick the next pop value
  always @(posedge clk) begin
    pixel_res_t want;
    if (rst_n && pop && !empty) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %0h", $time, out_new_pixel);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        check_field("new_pixel", want.pix, out_new_pixel);
        check_field("write_enable", 8'(want.wr), 8'(out_write_enable));
        check_field("row_end", 8'(want.row_end), 8'(out_row_end));
        check_field("rect_end", 8'(want.rect_end), 8'(out_rect_end));
        check_field("last_of_byte", 8'(want.last), 8'(out_last_of_byte));
        pixels_checked++;
        if (out_rect_end) rects_closed++;
      end
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else if (!quiet && $urandom_range(1, 100) <= pop_idle_pct) begin
      pop <= 1'b0;
      pop_gap = $urandom_range(0, 9);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic hold_inputs(input int n);
    push <= 1'b0;
    cfg_we <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    cfg_we <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    need_drain = 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_data <= v;
    @(posedge clk);
    shadow_write(r, v);
    cfg_writes++;
  endtask

  task automatic send_byte(input logic [7:0] s, input logic [63:0] o);
    cfg_we <= 1'b0;
    push <= 1'b1;
    in_src_byte <= s;
    in_old_pixels <= o;
    do @(posedge clk); while (full);
    items_sent++;
    need_drain = 1'b1;
  endtask

  task automatic send_random_byte();
    int n;
    if (!quiet && $urandom_range(1, 100) <= push_idle_pct) hold_inputs($urandom_range(1, 10));
    send_byte(8'($urandom), {$urandom, $urandom});
    n = expand_byte(in_src_byte, in_old_pixels);
    for (int k = 0; k < n; k++) pixel_q.push_back(byte_pix[k]);
  endtask

  function automatic logic [15:0] pick_value(input reg_idx_t r);
    int sel;
    sel = $urandom_range(0, 19);
    case (r)
      REG_FG_COLOR, REG_BG_COLOR: begin
        if (sel < 3) return 16'h0000;
        if (sel < 6) return 16'h00FF;
        return 16'($urandom);
      end
      REG_RECT_WIDTH: begin
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'(DIM_MAX);
        if (sel == 2) return 16'hFFFF;
        if (sel < 8) return 16'($urandom_range(1, 8));
        return 16'($urandom_range(1, 24));
      end
      REG_RECT_HEIGHT: begin
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'(DIM_MAX);
        if (sel == 2) return 16'h1FFF;
        return 16'($urandom_range(1, 6));
      end
      REG_SRC_STRIDE: begin
        if (sel < 2) return 16'h0000;
        if (sel < 4) return 16'h0001;
        if (sel < 6) return 16'hFFFF;
        return 16'($urandom);
      end
      default: begin
        if (sel < 5) return 16'($urandom);
        return 16'($urandom_range(0, 7));
      end
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  initial begin
    int n;
    int rand_sent;
    int span;
    bit first_phase;
    shadow_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) begin
        if (need_drain) drain();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        if ($urandom_range(1, 100) <= push_idle_pct) hold_inputs($urandom_range(1, 10));
        send_byte(PLAN[i].src, PLAN[i].old);
        n = expand_byte(PLAN[i].src, PLAN[i].old);
        if (PLAN[i].typed) begin
          pixel_q.push_back(PLAN[i].want);
        end else begin
          for (int k = 0; k < n; k++) pixel_q.push_back(byte_pix[k]);
        end
      end
    end

    rand_sent = 0;
    first_phase = 1'b1;
    while (rand_sent < RAND_ITEMS) begin
      drain();
      for (int r = 0; r < 8; r++) begin
        if (first_phase || $urandom_range(0, 1)) write_reg(reg_idx_t'(r), pick_value(reg_idx_t'(r)));
      end
      first_phase = 1'b0;
      quiet = (rand_sent >= RAND_ITEMS * 85 / 100);
      push_idle_pct = pick_idle_pct();
      pop_idle_pct = pick_idle_pct();
      span = $urandom_range(4, 30);
      for (int j = 0; j < span && rand_sent < RAND_ITEMS; j++) begin
        send_random_byte();
        rand_sent++;
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("Covered %0d source bytes and %0d register writes across all raster ops",
             items_sent, cfg_writes);
    $display("Checked %0d pixels, %0d rectangles closed", pixels_checked, rects_closed);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/mcer_pkg.sv
rtl/mcer_front.sv
rtl/mcer_queue.sv
rtl/mcer_back.sv
rtl/mono_color_expand_rop_core.sv
rtl/mcer_checker.sv
tb/mono_color_expand_rop_core_tb.sv
